[hw/rtl/burn_in_test_timer_core_macros.svh]
// Assertion macros shared by the burn-in timer RTL.
`ifndef BURN_IN_TEST_TIMER_CORE_MACROS_SVH
`define BURN_IN_TEST_TIMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BITT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("burn-in timer assertion failed");

// Next-cycle implication, disabled during reset.
`define BITT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("burn-in timer assertion failed");

`endif

[hw/rtl/bitt_pkg.sv]
// Types, constants and helpers for the burn-in test timer.
`default_nettype none

package bitt_pkg;

    localparam int PROBES  = 6;
    localparam int OK_W    = 6;
    localparam int TIME_W  = 24;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = TIME_W + PCT_W;
    localparam int SUM_W   = TIME_W + 1;
    localparam int SCL_W   = PROD_W + 1;
    localparam int KIND_W  = 3;
    localparam int LEVEL_W = 2;
    localparam int CIDX_W  = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // command codes
    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PAUSE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONTINUE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESET    = 3'd5;

    // current level codes
    localparam logic [LEVEL_W-1:0] LEVEL_LOW = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MID = 2'd1;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_DUR_LOW  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DUR_MID  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DUR_HIGH = 2'd2;
    localparam logic [CIDX_W-1:0] REG_OFF_PCT  = 2'd3;

    typedef logic [PROBES-1:0] probe_vec_t;

    typedef struct packed {
        logic              is_running;
        logic              is_paused;
        logic [TIME_W-1:0] elapsed_seconds;
        logic [OK_W-1:0]   probe_health;
        logic              finished;
        logic              start_accepted;
    } result_t;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        sat_inc = (v == TIME_MAX) ? TIME_MAX : v + TIME_W'(1);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bitt_out_buf.sv]
// Two-entry output buffer (result register plus skid stage) for the timer.
`default_nettype none

`include "burn_in_test_timer_core_macros.svh"

module bitt_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bitt_pkg::result_t push_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output bitt_pkg::result_t     out_data
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    bitt_pkg::result_t main_data_reg;
    bitt_pkg::result_t skid_data_reg;
    logic              take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                main_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                main_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

    `BITT_ASSERT_IMP(a_skid_behind_main, skid_valid_reg, main_valid_reg)
    `BITT_ASSERT_NXT(a_no_push_when_full, skid_valid_reg && !take, skid_valid_reg)
    `BITT_ASSERT_NXT(a_held_beat_stays, main_valid_reg && out_stall, main_valid_reg)

endmodule

`default_nettype wire

[hw/rtl/burn_in_test_timer_core.sv]
// Burn-in test timer: command decode, tick update and probe health checks.
//
// Usage: each input beat on in_valid/in_stall carries one command (kind)
// with current_level for a start and probe_ok for a tick. Every accepted beat
// yields exactly one result beat on out_valid/out_stall giving the timer
// flags, elapsed count and probe health after that command, plus the
// finished and start_accepted pulses.
// Results go to the output register, or to the skid stage if that is stalled.
// Throughput is one beat per cycle unless stalled; the state update and
// health compare of a tick, and the duration-by-percent product of a start,
// each fit between the state registers and the result register. The user
// must write configuration (cfg_we, cfg_index, cfg_data) only while idle; the
// block does not enforce it. A write is taken on any clock with cfg_we high.
// The output side has a result register and a skid stage, so one further beat
// is accepted while a result is stalled; in_stall rises only when both hold.
// Reset clears the flags, counts and configuration and sets all health bits.
`default_nettype none

`include "burn_in_test_timer_core_macros.svh"

module burn_in_test_timer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [bitt_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [bitt_pkg::TIME_W-1:0]   cfg_data,
    // command channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bitt_pkg::KIND_W-1:0]   kind,
    input  wire logic [bitt_pkg::LEVEL_W-1:0]  current_level,
    input  wire logic [bitt_pkg::OK_W-1:0]     probe_ok,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               is_running,
    output logic                               is_paused,
    output logic [bitt_pkg::TIME_W-1:0]        elapsed_seconds,
    output logic [bitt_pkg::OK_W-1:0]          probe_health,
    output logic                               finished,
    output logic                               start_accepted
);

    localparam int PROBES = bitt_pkg::PROBES;
    localparam int TIME_W = bitt_pkg::TIME_W;
    localparam int PCT_W  = bitt_pkg::PCT_W;
    localparam int PROD_W = bitt_pkg::PROD_W;
    localparam int SUM_W  = bitt_pkg::SUM_W;
    localparam int SCL_W  = bitt_pkg::SCL_W;

    // configuration registers
    logic [TIME_W-1:0] dur_low_reg;
    logic [TIME_W-1:0] dur_mid_reg;
    logic [TIME_W-1:0] dur_high_reg;
    logic [PCT_W-1:0]  off_pct_reg;

    // timer state
    logic                 running_reg,  running_next;
    logic                 paused_reg,   paused_next;
    logic [TIME_W-1:0]    duration_reg, duration_next;
    logic [TIME_W-1:0]    elapsed_reg,  elapsed_next;
    // duration * percent; the minimum on-time is this over 100
    logic [PROD_W-1:0]    min_prod_reg, min_prod_next;
    logic [TIME_W-1:0]    run_reg  [PROBES];
    logic [TIME_W-1:0]    run_next [PROBES];
    bitt_pkg::probe_vec_t health_reg, health_next;

    logic                 accept;
    logic                 buf_full;
    logic                 fin_pulse;
    logic                 start_pulse;
    logic                 tick_go;
    logic [TIME_W-1:0]    el_inc;
    logic [TIME_W-1:0]    remaining;
    logic [TIME_W-1:0]    dur_sel;
    bitt_pkg::probe_vec_t ok_vec;
    logic [TIME_W-1:0]    run_tick [PROBES];
    bitt_pkg::probe_vec_t low_on;
    bitt_pkg::result_t    res;
    bitt_pkg::result_t    out_res;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;
    assign ok_vec   = bitt_pkg::probe_vec_t'(probe_ok);

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_low_reg  <= '0;
            dur_mid_reg  <= '0;
            dur_high_reg <= '0;
            off_pct_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bitt_pkg::REG_DUR_LOW:  dur_low_reg  <= cfg_data;
                bitt_pkg::REG_DUR_MID:  dur_mid_reg  <= cfg_data;
                bitt_pkg::REG_DUR_HIGH: dur_high_reg <= cfg_data;
                bitt_pkg::REG_OFF_PCT:  off_pct_reg  <= cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // ----------------------------------------------------------- tick datapath
    assign tick_go   = running_reg && !paused_reg;
    assign el_inc    = bitt_pkg::sat_inc(elapsed_reg);
    assign remaining = (duration_reg > el_inc) ? duration_reg - el_inc : '0;

    // run + remaining <= floor(prod/100), saturated to 24 bits, becomes
    // 100*(run + remaining) <= prod together with run + remaining <= max.
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        logic [SCL_W-1:0] sum_ext;
        logic [SCL_W-1:0] sum100;
        for (int i = 0; i < PROBES; i++)
        begin
            run_tick[i] = ok_vec[i] ? bitt_pkg::sat_inc(run_reg[i]) : run_reg[i];
            sum         = SUM_W'(run_tick[i]) + SUM_W'(remaining);
            sum_ext     = SCL_W'(sum);
            sum100      = (sum_ext << 6) + (sum_ext << 5) + (sum_ext << 2);
            low_on[i]   = (sum100 <= SCL_W'(min_prod_reg))
                          && (sum <= SUM_W'(bitt_pkg::TIME_MAX));
        end
    end

    always_comb
    begin
        if (current_level == bitt_pkg::LEVEL_LOW)
        begin
            dur_sel = dur_low_reg;
        end
        else if (current_level == bitt_pkg::LEVEL_MID)
        begin
            dur_sel = dur_mid_reg;
        end
        else
        begin
            dur_sel = dur_high_reg;
        end
    end

    // ----------------------------------------------------------- next state
    always_comb
    begin
        running_next  = running_reg;
        paused_next   = paused_reg;
        duration_next = duration_reg;
        elapsed_next  = elapsed_reg;
        min_prod_next = min_prod_reg;
        health_next   = health_reg;
        fin_pulse     = 1'b0;
        start_pulse   = 1'b0;
        for (int i = 0; i < PROBES; i++)
        begin
            run_next[i] = run_reg[i];
        end

        unique case (kind)
            bitt_pkg::KIND_TICK:
            begin
                if (tick_go)
                begin
                    elapsed_next = el_inc;
                    for (int i = 0; i < PROBES; i++)
                    begin
                        run_next[i]    = run_tick[i];
                        health_next[i] = !low_on[i] && ok_vec[i];
                    end
                    if (el_inc >= duration_reg)
                    begin
                        running_next = 1'b0;
                        fin_pulse    = 1'b1;
                    end
                end
            end
            bitt_pkg::KIND_START:
            begin
                if (!running_reg)
                begin
                    duration_next = dur_sel;
                    elapsed_next  = '0;
                    running_next  = 1'b1;
                    paused_next   = 1'b0;
                    health_next   = '1;
                    min_prod_next = PROD_W'(dur_sel) * PROD_W'(off_pct_reg);
                    start_pulse   = 1'b1;
                    for (int i = 0; i < PROBES; i++)
                    begin
                        run_next[i] = '0;
                    end
                end
            end
            bitt_pkg::KIND_STOP:
            begin
                running_next = 1'b0;
                paused_next  = 1'b0;
            end
            bitt_pkg::KIND_PAUSE:
            begin
                paused_next = 1'b1;
            end
            bitt_pkg::KIND_CONTINUE:
            begin
                paused_next = 1'b0;
            end
            bitt_pkg::KIND_RESET:
            begin
                running_next  = 1'b0;
                paused_next   = 1'b0;
                duration_next = '0;
                elapsed_next  = '0;
                for (int i = 0; i < PROBES; i++)
                begin
                    run_next[i] = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            paused_reg   <= 1'b0;
            duration_reg <= '0;
            elapsed_reg  <= '0;
            min_prod_reg <= '0;
            health_reg   <= '1;
            for (int i = 0; i < PROBES; i++)
            begin
                run_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            running_reg  <= running_next;
            paused_reg   <= paused_next;
            duration_reg <= duration_next;
            elapsed_reg  <= elapsed_next;
            min_prod_reg <= min_prod_next;
            health_reg   <= health_next;
            for (int i = 0; i < PROBES; i++)
            begin
                run_reg[i] <= run_next[i];
            end
        end
    end

    // ------------------------------------------------------------- result
    always_comb
    begin
        res.is_running      = running_next;
        res.is_paused       = paused_next;
        res.elapsed_seconds = elapsed_next;
        res.probe_health    = bitt_pkg::OK_W'(health_next);
        res.finished        = fin_pulse;
        res.start_accepted  = start_pulse;
    end

    bitt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_res)
    );

    assign is_running      = out_res.is_running;
    assign is_paused       = out_res.is_paused;
    assign elapsed_seconds = out_res.elapsed_seconds;
    assign probe_health    = out_res.probe_health;
    assign finished        = out_res.finished;
    assign start_accepted  = out_res.start_accepted;

    `BITT_ASSERT_IMP(a_fin_stops, out_valid && finished, !is_running)
    `BITT_ASSERT_IMP(a_fin_xor_start, out_valid, !(finished && start_accepted))
    `BITT_ASSERT_IMP(a_start_clears, out_valid && start_accepted,
                     is_running && !is_paused && (elapsed_seconds == '0))
    `BITT_ASSERT_NXT(a_idle_tick_holds, accept && (kind == bitt_pkg::KIND_TICK) && !tick_go,
                     $stable(elapsed_reg) && $stable(health_reg))

endmodule

`default_nettype wire
